>>> hdl/lagged_fibonacci_range_rng_macros.svh
// Assertion helpers for the RTL, used by lfrr_back.
`ifndef LAGGED_FIBONACCI_RANGE_RNG_MACROS_SVH
`define LAGGED_FIBONACCI_RANGE_RNG_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LFRR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFRR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lfrr_pkg.sv
`timescale 1ns / 1ps
package lfrr_pkg;

  localparam int WORD_W    = 30;
  localparam int LAG_DEPTH = 55;
  localparam int SHORT_LAG = 24;
  localparam int TAP_START = LAG_DEPTH - SHORT_LAG;
  localparam int IDX_W     = $clog2(LAG_DEPTH);
  localparam int OUT_SHIFT = 6;
  localparam int MAX_TRIES = 4096;
  localparam int TRY_W     = $clog2(MAX_TRIES);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  typedef struct packed {
    logic valid;
    logic draw;
    logic multi;
  } cmd_ctl_t;

endpackage

>>> hdl/lfrr_ram.sv
`timescale 1ns / 1ps
module lfrr_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 55,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> hdl/lfrr_front.sv
`timescale 1ns / 1ps
module lfrr_front #(
  parameter int DRAW_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [lfrr_pkg::WORD_W-1:0] in_seed,
  input  logic [DRAW_WIDTH-1:0]     in_lo,
  input  logic [DRAW_WIDTH-1:0]     in_hi,
  output lfrr_pkg::cmd_ctl_t        cmd,
  input  logic                      cmd_ready,
  output logic [lfrr_pkg::WORD_W-1:0] cmd_seed,
  output logic [DRAW_WIDTH-1:0]     cmd_lo,
  output logic [DRAW_WIDTH-1:0]     cmd_diff,
  output logic [DRAW_WIDTH-1:0]     cmd_mask
);
  import lfrr_pkg::*;

  function automatic logic [DRAW_WIDTH-1:0] cover_mask(input logic [DRAW_WIDTH-1:0] d);
    logic [DRAW_WIDTH-1:0] m;
    m = d;
    for (int s = 1; s < DRAW_WIDTH; s = s * 2) begin
      m = m | (m >> s);
    end
    return m | DRAW_WIDTH'(1);
  endfunction

  logic                  q_draw  [QDEPTH];
  logic                  q_multi [QDEPTH];
  logic [WORD_W-1:0]     q_seed  [QDEPTH];
  logic [DRAW_WIDTH-1:0] q_lo    [QDEPTH];
  logic [DRAW_WIDTH-1:0] q_diff  [QDEPTH];
  logic [DRAW_WIDTH-1:0] q_mask  [QDEPTH];

  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  logic [DRAW_WIDTH-1:0] diff;

  assign in_ready = (count != (QPTR_W+1)'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = cmd.valid && cmd_ready;
  assign diff     = in_hi - in_lo;

  always_ff @(posedge clk) begin
    if (push) begin
      q_draw[wr_ptr]  <= (in_op == OP_DRAW);
      q_multi[wr_ptr] <= (in_hi > in_lo);
      q_seed[wr_ptr]  <= in_seed;
      q_lo[wr_ptr]    <= in_lo;
      q_diff[wr_ptr]  <= diff;
      q_mask[wr_ptr]  <= cover_mask(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign cmd.valid = (count != '0);
  assign cmd.draw  = q_draw[rd_ptr];
  assign cmd.multi = q_multi[rd_ptr];
  assign cmd_seed  = q_seed[rd_ptr];
  assign cmd_lo    = q_lo[rd_ptr];
  assign cmd_diff  = q_diff[rd_ptr];
  assign cmd_mask  = q_mask[rd_ptr];

endmodule

>>> hdl/lfrr_back.sv
`timescale 1ns / 1ps
`include "lagged_fibonacci_range_rng_macros.svh"
module lfrr_back #(
  parameter int DRAW_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lfrr_pkg::cmd_ctl_t          cmd,
  output logic                        cmd_ready,
  input  logic [lfrr_pkg::WORD_W-1:0] cmd_seed,
  input  logic [DRAW_WIDTH-1:0]       cmd_lo,
  input  logic [DRAW_WIDTH-1:0]       cmd_diff,
  input  logic [DRAW_WIDTH-1:0]       cmd_mask,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [DRAW_WIDTH-1:0]       out_value
);
  import lfrr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEED = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(LAG_DEPTH - 1)) ? '0 : x + IDX_W'(1);
  endfunction

  logic [2:0]            state;
  logic [IDX_W-1:0]      cnt;
  logic [IDX_W-1:0]      w;
  logic [IDX_W-1:0]      t;
  logic [TRY_W-1:0]      tries;
  logic                  seeded;
  logic [WORD_W-1:0]     prev_a;
  logic [WORD_W-1:0]     prev_b;
  logic [WORD_W-1:0]     seed_q;
  logic [DRAW_WIDTH-1:0] lo_q;
  logic [DRAW_WIDTH-1:0] diff_q;
  logic [DRAW_WIDTH-1:0] mask_q;
  logic                  multi_q;
  logic [DRAW_WIDTH-1:0] res;

  logic [IDX_W-1:0]      rd_addr_a;
  logic [IDX_W-1:0]      rd_addr_b;
  logic [WORD_W-1:0]     rd_a;
  logic [WORD_W-1:0]     rd_b;
  logic [WORD_W-1:0]     tab_a;
  logic [WORD_W-1:0]     tab_b;
  logic [WORD_W-1:0]     step_sum;
  logic [DRAW_WIDTH-1:0] step_v;
  logic                  hit;
  logic [WORD_W-1:0]     seed_word;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [WORD_W-1:0]     wdata;

  assign cmd_ready = (state == ST_IDLE);
  assign rd_addr_a = (state == ST_STEP) ? idx_inc(w) : w;
  assign rd_addr_b = (state == ST_STEP) ? idx_inc(t) : t;
  assign tab_a     = seeded ? rd_a : '0;
  assign tab_b     = seeded ? rd_b : '0;
  assign step_sum  = tab_a + tab_b;
  assign step_v    = step_sum[OUT_SHIFT +: DRAW_WIDTH] & mask_q;
  assign hit       = (step_v <= diff_q);

  always_comb begin
    if (cnt == '0) begin
      seed_word = seed_q;
    end else if (cnt == IDX_W'(1)) begin
      seed_word = WORD_W'(1);
    end else begin
      seed_word = prev_a + prev_b;
    end
  end

  assign we    = (state == ST_SEED) || (state == ST_STEP);
  assign waddr = (state == ST_SEED) ? cnt : w;
  assign wdata = (state == ST_SEED) ? seed_word : step_sum;

  lfrr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LAG_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (rd_addr_a),
    .rdata_a (rd_a),
    .raddr_b (rd_addr_b),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd.valid) begin
      seed_q  <= cmd_seed;
      lo_q    <= cmd_lo;
      diff_q  <= cmd_diff;
      mask_q  <= cmd_mask;
      multi_q <= cmd.multi;
      res     <= cmd_lo;
    end else if (state == ST_STEP && hit) begin
      res <= lo_q + step_v;
    end
    if (state == ST_SEED) begin
      prev_a <= prev_b;
      prev_b <= seed_word;
    end
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_value <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      w         <= '0;
      t         <= IDX_W'(TAP_START);
      tries     <= '0;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            cnt   <= '0;
            tries <= '0;
            if (!cmd.draw) begin
              state <= ST_SEED;
            end else if (cmd.multi) begin
              state <= ST_READ;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_SEED: begin
          cnt <= cnt + IDX_W'(1);
          if (cnt == IDX_W'(LAG_DEPTH - 1)) begin
            seeded <= 1'b1;
            w      <= '0;
            t      <= IDX_W'(TAP_START);
            state  <= ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_STEP;
        end
        ST_STEP: begin
          w <= idx_inc(w);
          t <= idx_inc(t);
          if (hit || tries == {TRY_W{1'b1}}) begin
            state <= ST_OUT;
          end else begin
            tries <= tries + TRY_W'(1);
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  logic [IDX_W:0] w_ext;
  logic [IDX_W:0] t_ext;
  logic [DRAW_WIDTH-1:0] res_off;
  logic lag_ok;
  logic draw_out;
  logic seed_last;
  logic seed_clean;

  assign w_ext      = (IDX_W+1)'(w);
  assign t_ext      = (IDX_W+1)'(t);
  assign res_off    = res - lo_q;
  assign lag_ok     = (t_ext == w_ext + (IDX_W+1)'(TAP_START)) ||
                      (t_ext + (IDX_W+1)'(SHORT_LAG) == w_ext);
  assign draw_out   = (state == ST_OUT) && multi_q;
  assign seed_last  = (state == ST_SEED) && (cnt == IDX_W'(LAG_DEPTH - 1));
  assign seed_clean = seeded && (w == '0) && (state == ST_IDLE);

  `LFRR_ASSERT_IMP(a_lag_gap, 1'b1, lag_ok, "tap and write index lost their lag")
  `LFRR_ASSERT_IMP(a_res_range, draw_out, (res_off <= diff_q), "draw result out of range")
  `LFRR_ASSERT_NXT(a_seed_done, seed_last, seed_clean, "reseed sweep did not finish cleanly")

endmodule

>>> hdl/lagged_fibonacci_range_rng.sv
`timescale 1ns / 1ps
// Additive lagged Fibonacci range generator (lags 55 and 24, 30-bit words).
// Input stream s_*: s_tuser selects reseed (0) or draw (1); s_tdata carries
// the seed and the requested range. Output stream m_*: one item per draw,
// none per reseed, in input order.
// A small command queue sits between the input side and the generator
// engine, so the input keeps accepting up to two items while the engine
// works or the output is stalled.
// Draw: the engine pops the command, reads the table and takes one
// generator step after another until a value falls in range, then loads
// the result into the output register; a range of a single value skips
// the read and the steps. The engine finishes one command before the next.
// Reseed: the engine sweeps the 55-word table one word per cycle and then
// returns to idle.
// Reset clears the queue, the output valid flag and the indices; until the
// first reseed the table reads as all zero.
// When m_tready is low the result holds in the output register, the engine
// waits, and the queue fills before s_tready drops.
module lagged_fibonacci_range_rng #(
  parameter int DRAW_WIDTH = 16,
  localparam int InW  = ((lfrr_pkg::WORD_W + 2 * DRAW_WIDTH + 7) / 8) * 8,
  localparam int OutW = ((DRAW_WIDTH + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [InW-1:0]  s_tdata,   // seed, range_low, range_high
  input  logic            s_tuser,   // op
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [OutW-1:0] m_tdata    // value
);
  import lfrr_pkg::*;

  cmd_ctl_t              cmd;
  logic                  cmd_ready;
  logic [WORD_W-1:0]     cmd_seed;
  logic [DRAW_WIDTH-1:0] cmd_lo;
  logic [DRAW_WIDTH-1:0] cmd_diff;
  logic [DRAW_WIDTH-1:0] cmd_mask;
  logic [DRAW_WIDTH-1:0] value;

  lfrr_front #(
    .DRAW_WIDTH (DRAW_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_seed   (s_tdata[WORD_W-1:0]),
    .in_lo     (s_tdata[WORD_W +: DRAW_WIDTH]),
    .in_hi     (s_tdata[WORD_W + DRAW_WIDTH +: DRAW_WIDTH]),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .cmd_seed  (cmd_seed),
    .cmd_lo    (cmd_lo),
    .cmd_diff  (cmd_diff),
    .cmd_mask  (cmd_mask)
  );

  lfrr_back #(
    .DRAW_WIDTH (DRAW_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .cmd_seed  (cmd_seed),
    .cmd_lo    (cmd_lo),
    .cmd_diff  (cmd_diff),
    .cmd_mask  (cmd_mask),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (value)
  );

  assign m_tdata = OutW'(value);

endmodule
